FILE: sv/mese_pkg.sv
// Shared types and operation codes for the media extract/saturate/extend unit.
// No dependencies.
package mese_pkg;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_SBFX   = 4'd0;
  localparam cmd_t CMD_UBFX   = 4'd1;
  localparam cmd_t CMD_SSAT   = 4'd2;
  localparam cmd_t CMD_USAT   = 4'd3;
  localparam cmd_t CMD_SSAT16 = 4'd4;
  localparam cmd_t CMD_USAT16 = 4'd5;
  localparam cmd_t CMD_SXTB   = 4'd6;
  localparam cmd_t CMD_UXTB   = 4'd7;
  localparam cmd_t CMD_SXTH   = 4'd8;
  localparam cmd_t CMD_UXTH   = 4'd9;
  localparam cmd_t CMD_SXTB16 = 4'd10;
  localparam cmd_t CMD_UXTB16 = 4'd11;

  // Largest meaningful extract or saturate width
  localparam logic [5:0] MAX_WIDTH = 6'd32;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] operand;
    logic [4:0]  lsb;
    logic [5:0]  field_width;
    logic [4:0]  shift_amount;
    logic        shift_arith;
    logic [5:0]  sat_width;
    logic [1:0]  rotate_bytes;
  } item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        sat_flag;
    logic        neg_flag;
    logic        zero_flag;
    logic        flags_valid;
  } res_t;

endpackage

FILE: sv/media_extract_saturate_extend_unit_top.sv
// Top level of the media extract/saturate/extend unit: three-stage pipeline.
// Depends on mese_pkg and mese_sat_lane.
// A result word passes through the stage 1, stage 2 and output registers before it
// is offered on res.
// Throughput: one word per cycle; each stage advances when the next one is
// empty or moving, so a stalled output holds the pipe without loss.
// Reset: synchronous, clears the stage valid bits; payload is not reset.
module media_extract_saturate_extend_unit_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  mese_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_ready,
  output mese_pkg::res_t  res
);
  import mese_pkg::*;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] word;
    logic [5:0]  fw;
    logic [5:0]  sat;
  } s1_t;

  typedef struct packed {
    logic [31:0] result;
    logic        sat_flag;
    logic        flags_valid;
  } s2_t;

  logic  v1, v2, v3;
  logic  en1, en2, en3;
  s1_t   s1, s1_next;
  s2_t   s2, s2_next;
  res_t  s3, s3_next;

  // Stall chain: a stage loads when it is empty or its contents move on
  assign en3        = !v3 || res_ready;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_ready = en1;
  assign res_valid  = v3;
  assign res        = s3;

  // Stage 1: shift or rotate the operand
  logic [63:0] rot_pair;
  assign rot_pair = {item.operand, item.operand} >> {item.rotate_bytes, 3'b000};

  always_comb begin
    s1_next.cmd = item.cmd;
    s1_next.fw  = (item.field_width > MAX_WIDTH) ? MAX_WIDTH : item.field_width;
    s1_next.sat = item.sat_width;
    case (item.cmd) inside
      CMD_SBFX, CMD_UBFX: begin
        s1_next.word = item.operand >> item.lsb;
      end
      CMD_SSAT, CMD_USAT: begin
        if (item.shift_arith) begin
          s1_next.word = 32'($signed(item.operand) >>> item.shift_amount);
        end else begin
          s1_next.word = item.operand << item.shift_amount;
        end
      end
      CMD_SSAT16, CMD_USAT16: begin
        s1_next.word = item.operand << item.shift_amount[1:0];
      end
      CMD_SXTB, CMD_UXTB, CMD_SXTH, CMD_UXTH, CMD_SXTB16, CMD_UXTB16: begin
        s1_next.word = rot_pair[31:0];
      end
      default: begin
        s1_next.word = 32'd0;
      end
    endcase
  end

  // Stage 2: extract masking, saturation lanes, extends
  logic [31:0] lane_a_in, lane_b_in, lane_a_out, lane_b_out;
  logic        lane_a_q, lane_b_q;
  logic        lane_unsigned;
  logic [31:0] fmask;
  logic [4:0]  sign_idx;
  logic        fsign;
  logic [31:0] w;

  assign w             = s1.word;
  assign lane_unsigned = (s1.cmd == CMD_USAT) || (s1.cmd == CMD_USAT16);
  assign lane_a_in     = ((s1.cmd == CMD_SSAT) || (s1.cmd == CMD_USAT)) ?
                         w : {{16{w[15]}}, w[15:0]};
  assign lane_b_in     = {{16{w[31]}}, w[31:16]};

  mese_sat_lane u_lane_a (
    .value         (lane_a_in),
    .width         (s1.sat),
    .unsigned_mode (lane_unsigned),
    .result        (lane_a_out),
    .clamped       (lane_a_q)
  );

  mese_sat_lane u_lane_b (
    .value         (lane_b_in),
    .width         (s1.sat),
    .unsigned_mode (lane_unsigned),
    .result        (lane_b_out),
    .clamped       (lane_b_q)
  );

  assign fmask    = (s1.fw == MAX_WIDTH) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << s1.fw[4:0]);
  assign sign_idx = 5'(s1.fw - 6'd1);
  assign fsign    = w[sign_idx];

  always_comb begin
    s2_next.sat_flag    = 1'b0;
    s2_next.flags_valid = 1'b0;
    case (s1.cmd) inside
      CMD_SBFX, CMD_UBFX: begin
        s2_next.flags_valid = 1'b1;
        if (s1.fw == 6'd0) begin
          s2_next.result = 32'd0;
        end else if ((s1.cmd == CMD_SBFX) && fsign) begin
          s2_next.result = (w & fmask) | ~fmask;
        end else begin
          s2_next.result = w & fmask;
        end
      end
      CMD_SSAT, CMD_USAT: begin
        s2_next.result   = lane_a_out;
        s2_next.sat_flag = lane_a_q;
      end
      CMD_SSAT16, CMD_USAT16: begin
        s2_next.result   = {lane_b_out[15:0], lane_a_out[15:0]};
        s2_next.sat_flag = lane_a_q || lane_b_q;
      end
      CMD_SXTB:   s2_next.result = {{24{w[7]}}, w[7:0]};
      CMD_UXTB:   s2_next.result = {24'd0, w[7:0]};
      CMD_SXTH:   s2_next.result = {{16{w[15]}}, w[15:0]};
      CMD_UXTH:   s2_next.result = {16'd0, w[15:0]};
      CMD_SXTB16: s2_next.result = {{8{w[23]}}, w[23:16], {8{w[7]}}, w[7:0]};
      CMD_UXTB16: s2_next.result = {8'd0, w[23:16], 8'd0, w[7:0]};
      default: begin
        s2_next.result = 32'd0;
      end
    endcase
  end

  // Stage 3: condition flags
  always_comb begin
    s3_next.result      = s2.result;
    s3_next.sat_flag    = s2.sat_flag;
    s3_next.flags_valid = s2.flags_valid;
    s3_next.neg_flag    = s2.flags_valid && s2.result[31];
    s3_next.zero_flag   = s2.flags_valid && (s2.result == 32'd0);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
  end

  // A held stage keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en2) |=> (v1 && $stable(s1)))
    else $error("stage 1 word changed while stalled");

  // Saturation is raised only by saturating operations
  a_q_source: assert property (@(posedge clk) disable iff (rst)
    (v1 && s2_next.sat_flag) |-> ((s1.cmd == CMD_SSAT) || (s1.cmd == CMD_USAT) ||
                                  (s1.cmd == CMD_SSAT16) || (s1.cmd == CMD_USAT16)))
    else $error("saturation flag from a non-saturating operation");

  // N and Z only move for extracts
  a_nz_gate: assert property (@(posedge clk) disable iff (rst)
    (v3 && !s3.flags_valid) |-> (!s3.neg_flag && !s3.zero_flag))
    else $error("N/Z set without flag update");

  // Unsigned saturate of a full word never yields a negative value
  a_usat_pos: assert property (@(posedge clk) disable iff (rst)
    (v1 && (s1.cmd == CMD_USAT)) |-> !s2_next.result[31])
    else $error("unsigned saturate produced a negative result");

endmodule

FILE: sv/mese_sat_lane.sv
// One 32-bit signed/unsigned saturation lane.
// Depends on mese_pkg for the width limit.
module mese_sat_lane (
  input  logic [31:0] value,
  input  logic [5:0]  width,
  input  logic        unsigned_mode,
  output logic [31:0] result,
  output logic        clamped
);
  import mese_pkg::*;

  logic [5:0]  ns;
  logic [5:0]  nu;
  logic [4:0]  ns_m1;
  logic [31:0] mask_s;
  logic [31:0] mask_u;
  logic        fits_s;
  logic        over_u;

  // Clip the widths to the legal ranges
  always_comb begin
    if (width == 6'd0) begin
      ns = 6'd1;
    end else if (width > MAX_WIDTH) begin
      ns = MAX_WIDTH;
    end else begin
      ns = width;
    end
    nu = (width > MAX_WIDTH) ? MAX_WIDTH : width;
  end

  // Bits above the kept range, signed and unsigned
  assign ns_m1  = 5'(ns - 6'd1);
  assign mask_s = 32'hFFFF_FFFF << ns_m1;
  assign mask_u = (nu == MAX_WIDTH) ? 32'd0 : (32'hFFFF_FFFF << nu[4:0]);
  assign fits_s = ((value & mask_s) == 32'd0) || ((value & mask_s) == mask_s);
  assign over_u = |(value & mask_u);

  // Clamp to the lower or upper bound
  always_comb begin
    if (unsigned_mode) begin
      if (value[31]) begin
        result  = 32'd0;
        clamped = 1'b1;
      end else if (over_u) begin
        result  = ~mask_u;
        clamped = 1'b1;
      end else begin
        result  = value;
        clamped = 1'b0;
      end
    end else begin
      clamped = !fits_s;
      if (fits_s) begin
        result = value;
      end else if (value[31]) begin
        result = mask_s;
      end else begin
        result = ~mask_s;
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for media_extract_saturate_extend_unit_top.
// Depends on mese_pkg; runs a directed table, then random words under three idle mixes,
// and checks every result word against a local predictor of the extract/saturate/extend math.
`timescale 1ns / 1ps

module tb_top;
  import mese_pkg::*;

  // Opcodes past the defined set; the unit must return zero with all flags clear
  localparam cmd_t CMD_RSVD_FIRST = 4'd12;
  localparam cmd_t CMD_RSVD_LAST  = 4'd15;
  localparam int HOLD_OFF_CYCLES  = 60;

  typedef struct {
    item_t stim;
    bit    typed;
    res_t  want;
  } dir_row_t;

  logic  clk;
  logic  rst;
  logic  item_valid;
  logic  item_ready;
  item_t in_word;
  logic  res_valid;
  logic  res_ready;
  res_t  out_word;

  res_t     pending_results[$];
  dir_row_t dir_rows[$];
  int       err_count;
  int       words_sent;
  int       results_checked;
  int       tx_idle_pct;
  int       rx_stall_pct;
  bit       hold_off_req;

  media_extract_saturate_extend_unit_top u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (in_word),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, results_checked);
    err_count++;
  endtask

  // Signed clamp to n bits; width below 1 acts as 1, above 32 as 32
  function automatic longint clamp_to_signed(input longint v, input int n, inout bit clipped);
    longint hi;
    longint lo;
    if (n < 1) n = 1;
    if (n > int'(MAX_WIDTH)) n = int'(MAX_WIDTH);
    hi = (longint'(1) << (n - 1)) - 1;
    lo = -(longint'(1) << (n - 1));
    if (v > hi) begin
      clipped = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clipped = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Unsigned clamp to 0 .. 2^n-1; width above 32 acts as 32
  function automatic longint clamp_to_unsigned(input longint v, input int n, inout bit clipped);
    longint hi;
    if (n > int'(MAX_WIDTH)) n = int'(MAX_WIDTH);
    hi = (longint'(1) << n) - 1;
    if (v < 0) begin
      clipped = 1'b1;
      return 0;
    end
    if (v > hi) begin
      clipped = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // Compute the result word the unit should return for one input word
  function automatic res_t media_result(input item_t w);
    res_t        r;
    logic [31:0] val;
    logic [31:0] mask;
    logic [31:0] shifted;
    logic [31:0] rot_word;
    logic [63:0] both;
    logic [63:0] lo_v;
    logic [63:0] hi_v;
    int          fw;
    bit          clipped;
    r       = '0;
    val     = '0;
    clipped = 1'b0;
    fw      = w.field_width;
    if (fw > int'(MAX_WIDTH)) fw = int'(MAX_WIDTH);
    both     = {w.operand, w.operand} >> (8 * w.rotate_bytes);
    rot_word = both[31:0];
    case (w.cmd)
      CMD_SBFX, CMD_UBFX: begin
        // bits above 31 read as zero, so the sign comes from the shifted word
        val = w.operand >> w.lsb;
        if (fw == 0) begin
          val = '0;
        end else if (fw < int'(MAX_WIDTH)) begin
          mask = (32'h1 << fw) - 32'h1;
          val  = val & mask;
          if (w.cmd == CMD_SBFX && val[fw-1]) val = val | ~mask;
        end
        r.flags_valid = 1'b1;
        r.neg_flag    = val[31];
        r.zero_flag   = (val == '0);
      end
      CMD_SSAT, CMD_USAT: begin
        if (w.shift_arith) shifted = $signed(w.operand) >>> w.shift_amount;
        else shifted = w.operand << w.shift_amount;
        if (w.cmd == CMD_SSAT)
          lo_v = clamp_to_signed(longint'($signed(shifted)), w.sat_width, clipped);
        else
          lo_v = clamp_to_unsigned(longint'($signed(shifted)), w.sat_width, clipped);
        val = lo_v[31:0];
      end
      CMD_SSAT16, CMD_USAT16: begin
        shifted = w.operand << w.shift_amount[1:0];
        if (w.cmd == CMD_SSAT16) begin
          lo_v = clamp_to_signed(longint'($signed(shifted[15:0])), w.sat_width, clipped);
          hi_v = clamp_to_signed(longint'($signed(shifted[31:16])), w.sat_width, clipped);
        end else begin
          lo_v = clamp_to_unsigned(longint'($signed(shifted[15:0])), w.sat_width, clipped);
          hi_v = clamp_to_unsigned(longint'($signed(shifted[31:16])), w.sat_width, clipped);
        end
        val = {hi_v[15:0], lo_v[15:0]};
      end
      CMD_SXTB:   val = {{24{rot_word[7]}}, rot_word[7:0]};
      CMD_UXTB:   val = {24'h0, rot_word[7:0]};
      CMD_SXTH:   val = {{16{rot_word[15]}}, rot_word[15:0]};
      CMD_UXTH:   val = {16'h0, rot_word[15:0]};
      CMD_SXTB16: val = {{8{rot_word[23]}}, rot_word[23:16], {8{rot_word[7]}}, rot_word[7:0]};
      CMD_UXTB16: val = {8'h0, rot_word[23:16], 8'h0, rot_word[7:0]};
      default:    val = '0;
    endcase
    r.result   = val;
    r.sat_flag = clipped;
    return r;
  endfunction

  function automatic item_t pack_word(input cmd_t c, input logic [31:0] op,
                                      input logic [4:0] lsb, input logic [5:0] fw,
                                      input logic [4:0] sh, input logic arith,
                                      input logic [5:0] sat, input logic [1:0] rot);
    item_t w;
    w.cmd          = c;
    w.operand      = op;
    w.lsb          = lsb;
    w.field_width  = fw;
    w.shift_amount = sh;
    w.shift_arith  = arith;
    w.sat_width    = sat;
    w.rotate_bytes = rot;
    return w;
  endfunction

  function automatic void add_row(input item_t stim, input bit typed, input res_t want);
    dir_row_t row;
    row.stim  = stim;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Random word: mostly legal opcodes and widths, operands mixed between
  // full random, small signed values and boundary patterns
  function automatic item_t random_word();
    item_t       w;
    logic [31:0] op;
    int          bits;
    int          sh;
    if ($urandom_range(0, 99) < 4) w.cmd = cmd_t'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
    else w.cmd = cmd_t'($urandom_range(CMD_SBFX, CMD_UXTB16));
    case ($urandom_range(0, 3))
      0, 1: op = $urandom;
      2: begin
        bits = $urandom_range(1, 32);
        sh   = 32 - bits;
        op   = $urandom;
        op   = 32'($signed(op << sh) >>> sh);
      end
      default: begin
        case ($urandom_range(0, 7))
          0: op = 32'h0000_0000;
          1: op = 32'h0000_0001;
          2: op = 32'h7FFF_FFFF;
          3: op = 32'h8000_0000;
          4: op = 32'hFFFF_FFFF;
          5: op = 32'h7FFF_8000;
          6: op = 32'h8000_7FFF;
          default: op = 32'h0080_FF7F;
        endcase
      end
    endcase
    w.operand      = op;
    w.lsb          = 5'($urandom);
    w.shift_amount = 5'($urandom);
    w.shift_arith  = 1'($urandom);
    w.rotate_bytes = 2'($urandom);
    if ($urandom_range(0, 99) < 80) w.field_width = 6'($urandom_range(1, 32));
    else w.field_width = 6'($urandom);
    if ($urandom_range(0, 99) < 80) w.sat_width = 6'($urandom_range(0, 32));
    else w.sat_width = 6'($urandom);
    return w;
  endfunction

  // Offer one word; hold valid and payload until the unit takes it
  task automatic send_word(input item_t w, input res_t want);
    bit taken;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    in_word    <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (item_ready) begin
        pending_results.push_back(want);
        words_sent++;
        taken = 1'b1;
      end
      @(posedge clk);
    end
  endtask

  task automatic run_random(input int count);
    item_t w;
    repeat (count) begin
      w = random_word();
      send_word(w, media_result(w));
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", got.result, '0);
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (got.result !== want.result) report_mismatch("result", got.result, want.result);
    if (got.sat_flag !== want.sat_flag)
      report_mismatch("sat_flag", 32'(got.sat_flag), 32'(want.sat_flag));
    if (got.neg_flag !== want.neg_flag)
      report_mismatch("neg_flag", 32'(got.neg_flag), 32'(want.neg_flag));
    if (got.zero_flag !== want.zero_flag)
      report_mismatch("zero_flag", 32'(got.zero_flag), 32'(want.zero_flag));
    if (got.flags_valid !== want.flags_valid)
      report_mismatch("flags_valid", 32'(got.flags_valid), 32'(want.flags_valid));
  endtask

  // Output side: random stalls, plus a long hold-off on request
  initial begin : rx_proc
    int hold_left;
    bit take;
    hold_left = 0;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        take = 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        take         = 1'b0;
      end else begin
        take = ($urandom_range(0, 99) >= rx_stall_pct);
      end
      res_ready <= take;
      @(negedge clk);
      if (!rst && res_valid && res_ready) check_result(out_word);
    end
  end

  initial begin : main_proc
    int i;
    err_count       = 0;
    words_sent      = 0;
    results_checked = 0;
    hold_off_req    = 1'b0;
    tx_idle_pct     = 7;
    rx_stall_pct    = 67;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    in_word    <= '0;

    // Directed table: extremes of every field, each opcode, each corner
    add_row(pack_word(CMD_UBFX, 32'hFFFF_FFFF, 5'd0, 6'd32, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1});
    // field that runs past bit 31, one bit wide and wider
    add_row(pack_word(CMD_SBFX, 32'h8000_0000, 5'd31, 6'd1, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1});
    add_row(pack_word(CMD_SBFX, 32'h8000_0000, 5'd31, 6'd4, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b1});
    // zero extract width
    add_row(pack_word(CMD_UBFX, 32'hFFFF_FFFF, 5'd5, 6'd0, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1});
    // extract width above 32
    add_row(pack_word(CMD_SBFX, 32'h1234_5678, 5'd4, 6'd63, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'h0123_4567, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(pack_word(CMD_SSAT, 32'h7FFF_FFFF, 5'd0, 6'd0, 5'd0, 1'b0, 6'd16, 2'd0), 1'b1,
            '{32'h0000_7FFF, 1'b1, 1'b0, 1'b0, 1'b0});
    // signed saturate width zero behaves as one
    add_row(pack_word(CMD_SSAT, 32'h8000_0000, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_SSAT, 32'h4000_0000, 5'd0, 6'd0, 5'd1, 1'b0, 6'd32, 2'd0), 1'b1,
            '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0});
    // arithmetic shift by zero means no shift; width above 32
    add_row(pack_word(CMD_SSAT, 32'h8000_0000, 5'd0, 6'd0, 5'd0, 1'b1, 6'd63, 2'd0), 1'b1,
            '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_SSAT, 32'h8000_0000, 5'd0, 6'd0, 5'd31, 1'b1, 6'd8, 2'd0), 1'b1,
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0});
    // unsigned saturate: wide width clamps only negatives, width zero clamps to zero
    add_row(pack_word(CMD_USAT, 32'h8000_0000, 5'd0, 6'd0, 5'd0, 1'b0, 6'd63, 2'd0), 1'b1,
            '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_USAT, 32'h0000_0001, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_USAT, 32'h0000_FFFF, 5'd0, 6'd0, 5'd7, 1'b0, 6'd31, 2'd0), 1'b0, '0);
    add_row(pack_word(CMD_SSAT16, 32'h7FFF_8000, 5'd0, 6'd0, 5'd31, 1'b0, 6'd1, 2'd0),
            1'b0, '0);
    add_row(pack_word(CMD_SSAT16, 32'h8000_7FFF, 5'd0, 6'd0, 5'd0, 1'b0, 6'd16, 2'd0),
            1'b0, '0);
    // unsigned lane saturate: negative lane still clamps at wide width
    add_row(pack_word(CMD_USAT16, 32'h8000_7FFF, 5'd0, 6'd0, 5'd0, 1'b0, 6'd63, 2'd0), 1'b1,
            '{32'h0000_7FFF, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_USAT16, 32'h0001_0001, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_SXTB, 32'h0000_0080, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'hFFFF_FF80, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_UXTB, 32'h8000_0000, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd3), 1'b1,
            '{32'h0000_0080, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_SXTH, 32'h8000_0000, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd2), 1'b1,
            '{32'hFFFF_8000, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_UXTH, 32'h1234_5678, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd1), 1'b0, '0);
    add_row(pack_word(CMD_SXTB16, 32'h0080_0080, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd0), 1'b1,
            '{32'hFF80_FF80, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_UXTB16, 32'hA5B6_C7D8, 5'd0, 6'd0, 5'd0, 1'b0, 6'd0, 2'd1),
            1'b0, '0);
    // reserved opcodes give zero and clear flags
    add_row(pack_word(CMD_RSVD_FIRST, 32'hFFFF_FFFF, 5'd31, 6'd63, 5'd31, 1'b1, 6'd63, 2'd3),
            1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(pack_word(CMD_RSVD_LAST, 32'h8000_0001, 5'd0, 6'd1, 5'd1, 1'b0, 6'd1, 2'd0),
            1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Light sender gaps, heavy output stalls
    for (i = 0; i < dir_rows.size(); i++) begin
      send_word(dir_rows[i].stim,
                dir_rows[i].typed ? dir_rows[i].want : media_result(dir_rows[i].stim));
    end
    run_random(230);
    wait_drained();

    // Heavy sender gaps, light output stalls
    tx_idle_pct  = 67;
    rx_stall_pct = 7;
    run_random(240);

    // No idling; hold the output long enough to back up the pipe
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_off_req = 1'b1;
    run_random(260);
    wait_drained();
    repeat (12) @(posedge clk);

    $display("Covered %0d input words over every opcode, reserved codes and width extremes;",
             words_sent);
    $display("%0d results compared under three idle mixes, a %0d-cycle output hold and drains.",
             results_checked, HOLD_OFF_CYCLES);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mese_pkg.sv
sv/mese_sat_lane.sv
sv/media_extract_saturate_extend_unit_top.sv
tb/tb_top.sv
